// File: hdl/dmc_pkg.sv
package dmc_pkg;

    // cordic and clearance datapath widths
    localparam int CZ_W     = 34;
    localparam int TRIG_W   = 28;
    localparam int STEP_W   = 5;
    localparam int ANGLE_W  = 16;
    localparam int CLR_W    = 23;
    localparam int ACC_W    = 64;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd25736;
    localparam logic signed [CZ_W-1:0]    CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CLR_W-1:0]   CLR_MAX     = 23'sd4194303;
    localparam logic signed [CLR_W-1:0]   CLR_MIN     = 23'sh400000;

    // action codes
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_EVAL   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_RSVD   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIM,
        S_LIST,
        S_SCAN,
        S_OUT
    } t_state;

    // arctangent of 2^-i in Q30
    function automatic logic signed [CZ_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [CZ_W-1:0] r;
        case (i)
            5'd0:    r = 34'sd843314857;
            5'd1:    r = 34'sd497837829;
            5'd2:    r = 34'sd263043837;
            5'd3:    r = 34'sd133525159;
            5'd4:    r = 34'sd67021687;
            5'd5:    r = 34'sd33543516;
            5'd6:    r = 34'sd16775851;
            5'd7:    r = 34'sd8388437;
            5'd8:    r = 34'sd4194283;
            5'd9:    r = 34'sd2097149;
            5'd10:   r = 34'sd1048576;
            5'd11:   r = 34'sd524288;
            5'd12:   r = 34'sd262144;
            5'd13:   r = 34'sd131072;
            5'd14:   r = 34'sd65536;
            5'd15:   r = 34'sd32768;
            5'd16:   r = 34'sd16384;
            5'd17:   r = 34'sd8192;
            5'd18:   r = 34'sd4096;
            5'd19:   r = 34'sd2048;
            5'd20:   r = 34'sd1024;
            5'd21:   r = 34'sd512;
            5'd22:   r = 34'sd256;
            5'd23:   r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/dmc_if.sv
interface dmc_in_if #(parameter int COORD_BITS = 20);
    import dmc_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic signed [COORD_BITS-1:0] draft;
    logic signed [ANGLE_W-1:0]    trim_angle;
    logic signed [ANGLE_W-1:0]    list_angle;

    modport source (output valid, action, pos_x, pos_y, pos_z, draft, trim_angle, list_angle,
                    input ready);
    modport sink   (input valid, action, pos_x, pos_y, pos_z, draft, trim_angle, list_angle,
                    output ready);
endinterface

interface dmc_out_if;
    import dmc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [CLR_W-1:0] min_clearance;
    logic [1:0]              status;

    modport source (output valid, min_clearance, status, input ready);
    modport sink   (input valid, min_clearance, status, output ready);
endinterface

// File: hdl/dmc_cordic.sv
module dmc_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [dmc_pkg::ANGLE_W-1:0]   i_angle,
    output logic                                 o_done,
    output logic signed [dmc_pkg::TRIG_W-1:0]    o_cos,
    output logic signed [dmc_pkg::TRIG_W-1:0]    o_sin
);
    import dmc_pkg::*;

    logic signed [CZ_W-1:0]    r_x, r_y, r_z;
    logic signed [CZ_W-1:0]    n_x, n_y, n_z;
    logic signed [CZ_W-1:0]    dx, dy, z0;
    logic signed [ANGLE_W-1:0] ang_c;
    logic [STEP_W-1:0]         r_i;
    logic                      r_busy, r_done;
    logic                      last;

    // clamp angle and move to Q4.30
    always_comb begin
        ang_c = i_angle;
        if (i_angle > ANGLE_LIMIT) ang_c = ANGLE_LIMIT;
        if (i_angle < -ANGLE_LIMIT) ang_c = -ANGLE_LIMIT;
        z0 = CZ_W'(ang_c) <<< 16;
    end

    // one micro-rotation per cycle
    always_comb begin
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        if (!r_z[CZ_W-1]) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - atan_q30(r_i);
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + atan_q30(r_i);
        end
    end

    assign last = (r_i == STEP_W'(STEPS - 1));

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) r_busy <= 1'b1;
            else if (last) r_busy <= 1'b0;
        end
    end

    // rotation registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            r_z <= z0;
            r_i <= '0;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_i <= r_i + STEP_W'(1);
        end
    end

    // round Q30 to Q24
    logic signed [CZ_W-1:0] cx, cy;
    assign cx = (r_x + CZ_W'(32)) >>> 6;
    assign cy = (r_y + CZ_W'(32)) >>> 6;
    assign o_cos  = cx[TRIG_W-1:0];
    assign o_sin  = cy[TRIG_W-1:0];
    assign o_done = r_done;

endmodule

// File: hdl/dmc_mac.sv
module dmc_mac #(
    parameter int COORD_BITS = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [COORD_BITS-1:0]        i_x,
    input  logic signed [COORD_BITS-1:0]        i_y,
    input  logic signed [COORD_BITS-1:0]        i_z,
    input  logic signed [COORD_BITS-1:0]        i_draft,
    input  logic signed [dmc_pkg::TRIG_W-1:0]   i_cl,
    input  logic signed [dmc_pkg::TRIG_W:0]     i_szsum,
    input  logic signed [dmc_pkg::TRIG_W-1:0]   i_st,
    output logic                                o_valid,
    output logic                                o_busy,
    output logic signed [dmc_pkg::CLR_W-1:0]    o_v
);
    import dmc_pkg::*;

    localparam int RW = ACC_W - 24;

    logic                    r_v1, r_v2, r_v3;
    logic signed [ACC_W-1:0] r_py, r_pz, r_px, r_acc;
    logic signed [CLR_W-1:0] r_out;
    logic signed [ACC_W-1:0] rnd;
    logic signed [RW:0]      v;

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // round and subtract draft (saturated in the result register)
    always_comb begin
        rnd = (r_acc + (ACC_W'(1) <<< 23)) >>> 24;
        v   = (RW+1)'(rnd) - (RW+1)'(i_draft);
    end

    // products, sum, result
    always_ff @(posedge i_clk) begin
        r_py  <= ACC_W'(i_y) * ACC_W'(i_cl);
        r_pz  <= ACC_W'(i_z) * ACC_W'(i_szsum);
        r_px  <= ACC_W'(i_x) * ACC_W'(i_st);
        r_acc <= r_py - r_pz - r_px;
        if (v > (RW+1)'(CLR_MAX)) r_out <= CLR_MAX;
        else if (v < (RW+1)'(CLR_MIN)) r_out <= CLR_MIN;
        else r_out <= v[CLR_W-1:0];
    end

    assign o_valid = r_v3;
    assign o_busy  = r_v1 | r_v2 | r_v3;
    assign o_v     = r_out;

endmodule

// File: hdl/downflooding_min_clearance.sv
// channel | dir | handshake          | payload
// i_in    | in  | valid/ready        | action, pos_x/y/z, draft, trim_angle, list_angle
// o_out   | out | valid/ready        | min_clearance, status
//
// append, clear and bad actions, and evaluate on an empty table: result registered in the cycle after acceptance
// evaluate: trim, then list angle in the shared cordic unit,
// then one opening per cycle from the table memory through the read register and the multiply pipe
// one transaction at a time: i_in.ready is high only while idle
// o_out holds its result until taken; reset empties the table, contents stay unset
module downflooding_min_clearance #(
    parameter int MAX_OPENINGS = 64,
    parameter int COORD_BITS   = 20,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dmc_in_if.sink       i_in,
    dmc_out_if.source    o_out
);
    import dmc_pkg::*;

    localparam int AW = (MAX_OPENINGS > 1) ? $clog2(MAX_OPENINGS) : 1;
    localparam int CW = $clog2(MAX_OPENINGS + 1);
    localparam int EW = 3 * COORD_BITS;

    t_state r_state, n_state;

    logic [CW-1:0]                r_count, r_idx;
    logic [EW-1:0]                r_mem [MAX_OPENINGS];
    logic [EW-1:0]                r_rd_data;
    logic                         r_rdv;
    logic signed [COORD_BITS-1:0] r_draft;
    logic signed [ANGLE_W-1:0]    r_list;
    logic signed [TRIG_W-1:0]     r_st, r_cl;
    logic signed [TRIG_W:0]       r_szsum;
    logic signed [CLR_W-1:0]      r_clr;
    logic [1:0]                   r_status;

    logic                         accept, full, empty, issue, wr_en, scan_done;
    logic                         cs_start, cs_done, mac_valid, mac_busy;
    logic signed [ANGLE_W-1:0]    cs_angle;
    logic signed [TRIG_W-1:0]     cs_cos, cs_sin;
    logic signed [CLR_W-1:0]      mac_v;

    assign accept = i_in.valid && i_in.ready;
    assign full   = (r_count == CW'(MAX_OPENINGS));
    assign empty  = (r_count == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) begin
                n_state = (i_in.action == ACT_EVAL && !empty) ? S_TRIM : S_OUT;
            end
            S_TRIM: if (cs_done) n_state = S_LIST;
            S_LIST: if (cs_done) n_state = S_SCAN;
            S_SCAN: if (scan_done) n_state = S_OUT;
            S_OUT:  if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        o_out.valid = (r_state == S_OUT);
        cs_start = 1'b0;
        cs_angle = r_list;
        issue = 1'b0;
        wr_en = 1'b0;
        scan_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                cs_angle = i_in.trim_angle;
                cs_start = accept && i_in.action == ACT_EVAL && !empty;
                wr_en = accept && i_in.action == ACT_APPEND && !full;
            end
            S_TRIM: cs_start = cs_done;
            S_SCAN: begin
                issue = (r_idx != r_count);
                scan_done = !issue && !r_rdv && !mac_busy;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // opening count and read strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rdv   <= 1'b0;
        end else begin
            r_rdv <= issue;
            if (wr_en) r_count <= r_count + CW'(1);
            else if (accept && i_in.action == ACT_CLEAR) r_count <= '0;
        end
    end

    // opening table memory
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_count[AW-1:0]] <= {i_in.pos_x, i_in.pos_y, i_in.pos_z};
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    // evaluation datapath and result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_draft  <= i_in.draft;
            r_list   <= i_in.list_angle;
            r_clr    <= '0;
            r_status <= ST_OK;
            case (i_in.action)
                ACT_APPEND: if (full) r_status <= ST_FULL;
                ACT_EVAL: begin
                    r_clr <= CLR_MAX;
                    if (empty) r_status <= ST_EMPTY;
                end
                ACT_CLEAR: ;
                default: r_status <= ST_BAD;
            endcase
        end
        if (r_state == S_TRIM && cs_done) r_st <= cs_sin;
        if (r_state == S_LIST && cs_done) begin
            r_cl    <= cs_cos;
            r_szsum <= (TRIG_W+1)'(cs_sin) + (TRIG_W+1)'(r_st);
            r_idx   <= '0;
        end else if (issue) begin
            r_idx <= r_idx + CW'(1);
        end
        if (mac_valid && mac_v < r_clr) r_clr <= mac_v;
    end

    dmc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cs_start),
        .i_angle (cs_angle),
        .o_done  (cs_done),
        .o_cos   (cs_cos),
        .o_sin   (cs_sin)
    );

    dmc_mac #(.COORD_BITS(COORD_BITS)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rdv),
        .i_x     (r_rd_data[EW-1 -: COORD_BITS]),
        .i_y     (r_rd_data[2*COORD_BITS-1 -: COORD_BITS]),
        .i_z     (r_rd_data[COORD_BITS-1:0]),
        .i_draft (r_draft),
        .i_cl    (r_cl),
        .i_szsum (r_szsum),
        .i_st    (r_st),
        .o_valid (mac_valid),
        .o_busy  (mac_busy),
        .o_v     (mac_v)
    );

    assign o_out.min_clearance = r_clr;
    assign o_out.status        = r_status;

endmodule
